// ===== rtl/core/orb_pkg.sv =====
`default_nettype none
// ============================================================================
// orb_pkg: shared types and codes for the offset reassembly buffer
// Payload structs, operation and slot status codes, controller interface.
// ============================================================================
package orb_pkg;

    localparam int STORE_BYTES_DEF = 65536;

    localparam int OFFSET_W   = 16;
    localparam int DATA_W     = 8;
    localparam int SPAN_W     = 17;
    localparam int CONFLICT_W = 24;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] ST_ABSENT = 2'd0;
    localparam logic [1:0] ST_CLEAN  = 2'd1;
    localparam logic [1:0] ST_UNCORR = 2'd2;

    localparam logic [CONFLICT_W-1:0] CONFLICT_MAX = '1;

    typedef struct packed {
        logic [1:0]          op;
        logic [OFFSET_W-1:0] byte_offset;
        logic [DATA_W-1:0]   write_data;
        logic                clean;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0]     read_byte;
        logic                  byte_present;
        logic [SPAN_W-1:0]     span_bytes;
        logic [OFFSET_W-1:0]   lowest_offset;
        logic [CONFLICT_W-1:0] conflict_count;
    } t_out_item;

    typedef struct packed {
        logic sweep;
        logic capture;
        logic exec;
    } t_ctl_cmd;

    typedef struct packed {
        logic sweep_last;
        logic op_clear;
    } t_ctl_stat;

endpackage
`default_nettype wire

// ===== rtl/core/offset_reassembly_buffer.sv =====
`default_nettype none
// ============================================================================
// offset_reassembly_buffer: byte-wide fragment reassembly store
// Places bytes by absolute offset with clean-over-uncorrectable priority,
// reads them back, tracks span, lowest offset and clean conflicts.
// ============================================================================
//
//  channel   | signals                         | transfer
//  ----------+---------------------------------+------------------------------
//  command   | start, busy, i_item             | start high while busy low
//  result    | o_strobe, o_result              | one cycle, no backpressure
//  config    | i_cfg_valid, o_cfg_ready,       | valid and ready high
//            | i_cfg_data                      |
//
//  A read, write or unused op steps through capture with a registered store
//  read, then execute with the store write; the result shows the cycle after.
//  A clear steps through capture and execute, then a status sweep over all
//  STORE_BYTES slots, one slot per cycle through the status store write port;
//  busy stays high meanwhile. After reset the same sweep runs before busy drops.
//  Results cannot be stalled; the receiver takes each on its strobe.
//
module offset_reassembly_buffer
    import orb_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire t_in_item          i_item,
    output logic                   o_strobe,
    output t_out_item              o_result,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [DATA_W-1:0] i_cfg_data
);

    t_ctl_cmd  cmd;
    t_ctl_stat stat;

    assign o_cfg_ready = 1'b1;

    orb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    orb_datapath #(
        .STORE_BYTES (STORE_BYTES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_item      (i_item),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_result    (o_result),
        .o_strobe    (o_strobe)
    );

    // every strobe comes from exactly one execute step
    a_strobe_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(cmd.exec))
        else $error("result strobe without execute step");

    // an accepted transaction holds the command side off in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // an empty store reports no lowest offset
    a_empty_lowest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.span_bytes == '0) |-> (o_result.lowest_offset == '0))
        else $error("lowest offset set while span is zero");

    // sweep never overlaps a store update
    a_sweep_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.sweep && (cmd.exec || cmd.capture)))
        else $error("sweep overlaps a transaction");

endmodule
`default_nettype wire

// ===== rtl/core/orb_ctrl.sv =====
`default_nettype none
// ============================================================================
// orb_ctrl: sequencing for the offset reassembly buffer
// Steps each transaction through capture and execute, and runs the status
// clearing sweep after reset and after a clear operation.
// ============================================================================
module orb_ctrl
    import orb_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_start,
    input  wire t_ctl_stat i_stat,
    output t_ctl_cmd       o_cmd,
    output logic           o_busy
);

    typedef enum logic [1:0] {
        S_SWEEP,
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_SWEEP: begin
                if (i_stat.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = i_stat.op_clear ? S_SWEEP : S_IDLE;
            end
            default: begin
                n_state = S_SWEEP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.sweep   = (r_state == S_SWEEP);
    assign o_cmd.capture = (r_state == S_IDLE) && i_start;
    assign o_cmd.exec    = (r_state == S_EXEC);
    assign o_busy        = (r_state != S_IDLE);

endmodule
`default_nettype wire

// ===== rtl/core/orb_datapath.sv =====
`default_nettype none
// ============================================================================
// orb_datapath: byte store, slot status store and tracking registers
// Reads both stores on capture, applies the write priority on execute and
// registers one result per transaction.
// ============================================================================
module orb_datapath
    import orb_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_ctl_cmd          i_cmd,
    output t_ctl_stat              o_stat,
    input  wire t_in_item          i_item,
    input  wire logic              i_cfg_valid,
    input  wire logic [DATA_W-1:0] i_cfg_data,
    output t_out_item              o_result,
    output logic                   o_strobe
);

    localparam int AW = $clog2(STORE_BYTES);

    logic [DATA_W-1:0] r_byte_mem [STORE_BYTES];
    logic [1:0]        r_stat_mem [STORE_BYTES];

    t_in_item              r_item;
    logic                  r_in_range;
    logic [AW-1:0]         r_addr;
    logic [DATA_W-1:0]     r_rd_byte;
    logic [1:0]            r_rd_stat;
    logic [DATA_W-1:0]     r_fill;
    logic [SPAN_W-1:0]     r_span;
    logic [OFFSET_W-1:0]   r_lowest;
    logic                  r_any;
    logic [CONFLICT_W-1:0] r_conflict;
    logic [AW-1:0]         r_sweep_cnt;
    t_out_item             r_result;
    logic                  r_strobe;

    logic [AW+OFFSET_W-1:0] in_off_ext;
    logic [AW-1:0]          in_addr;
    logic                   in_range;
    logic                   op_write;
    logic                   op_read;
    logic                   op_clear;
    logic                   do_write;
    logic                   land;
    logic                   stat_we;
    logic [AW-1:0]          stat_waddr;
    logic [1:0]             stat_wdata;
    logic [SPAN_W-1:0]      pos_plus1;
    logic                   sweep_last;
    logic [SPAN_W-1:0]      n_span;
    logic [OFFSET_W-1:0]    n_lowest;
    logic                   n_any;
    logic [CONFLICT_W-1:0]  n_conflict;
    t_out_item              n_result;

    assign in_off_ext = (AW+OFFSET_W)'(i_item.byte_offset);
    assign in_addr    = in_off_ext[AW-1:0];
    assign in_range   = (32'(i_item.byte_offset) < 32'(STORE_BYTES));

    assign op_write = (r_item.op == OP_WRITE);
    assign op_read  = (r_item.op == OP_READ);
    assign op_clear = (r_item.op == OP_CLEAR);
    assign do_write = op_write && r_in_range;

    // clean always lands; uncorrectable only into an absent slot
    assign land = i_cmd.exec && do_write && (r_item.clean || r_rd_stat == ST_ABSENT);

    assign stat_we    = i_cmd.sweep || land;
    assign stat_waddr = i_cmd.sweep ? r_sweep_cnt : r_addr;
    assign stat_wdata = i_cmd.sweep ? ST_ABSENT : (r_item.clean ? ST_CLEAN : ST_UNCORR);

    assign sweep_last = (r_sweep_cnt == AW'(STORE_BYTES - 1));
    assign o_stat.sweep_last = sweep_last;
    assign o_stat.op_clear   = op_clear;

    assign pos_plus1 = SPAN_W'(r_item.byte_offset) + SPAN_W'(1);

    always_comb begin
        n_span     = r_span;
        n_lowest   = r_lowest;
        n_any      = r_any;
        n_conflict = r_conflict;
        n_result   = '0;
        if (op_clear) begin
            n_span     = '0;
            n_lowest   = '0;
            n_any      = 1'b0;
            n_conflict = '0;
        end else if (do_write) begin
            if (r_item.clean && r_rd_stat == ST_CLEAN && r_rd_byte != r_item.write_data
                && r_conflict != CONFLICT_MAX) begin
                n_conflict = r_conflict + CONFLICT_W'(1);
            end
            if (pos_plus1 > r_span) begin
                n_span = pos_plus1;
            end
            if (!r_any || r_item.byte_offset < r_lowest) begin
                n_lowest = r_item.byte_offset;
            end
            n_any = 1'b1;
        end
        if (op_read) begin
            if (r_in_range && r_rd_stat != ST_ABSENT) begin
                n_result.read_byte    = r_rd_byte;
                n_result.byte_present = 1'b1;
            end else begin
                n_result.read_byte = r_fill;
            end
        end
        n_result.span_bytes     = n_span;
        n_result.lowest_offset  = n_lowest;
        n_result.conflict_count = n_conflict;
    end

    // store ports: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (land) begin
            r_byte_mem[r_addr] <= r_item.write_data;
        end
        if (i_cmd.capture) begin
            r_rd_byte <= r_byte_mem[in_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stat_we) begin
            r_stat_mem[stat_waddr] <= stat_wdata;
        end
        if (i_cmd.capture) begin
            r_rd_stat <= r_stat_mem[in_addr];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item     <= i_item;
            r_in_range <= in_range;
            r_addr     <= in_addr;
        end
        if (i_cmd.exec) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_span      <= '0;
            r_lowest    <= '0;
            r_any       <= 1'b0;
            r_conflict  <= '0;
            r_sweep_cnt <= '0;
            r_strobe    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_fill <= i_cfg_data;
            end
            if (i_cmd.exec) begin
                r_span     <= n_span;
                r_lowest   <= n_lowest;
                r_any      <= n_any;
                r_conflict <= n_conflict;
            end
            if (i_cmd.sweep) begin
                r_sweep_cnt <= sweep_last ? '0 : r_sweep_cnt + AW'(1);
            end
            r_strobe <= i_cmd.exec;
        end
    end

    assign o_result = r_result;
    assign o_strobe = r_strobe;

endmodule
`default_nettype wire
